[hw/rtl/tpts_pkg.sv]
// Shared types and constants for the two-level priority task scheduler.
// No dependencies; imported by every scheduler module.
`timescale 1ns / 1ps

package tpts_pkg;

    localparam int ARR_W  = 16;
    localparam int WORK_W = 16;
    localparam int TIME_W = 23;
    localparam int TASK_W = ARR_W + WORK_W;

    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [WORK_W-1:0] work;
    } t_task;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_q_ctrl;

endpackage

[hw/rtl/tpts_queue.sv]
// One priority FIFO: task index plus arrival and work time in a synchronous memory.
// Head entry is prefetched so it is valid in the cycle after any pop. Depends on tpts_pkg.
`timescale 1ns / 1ps

module tpts_queue #(
    parameter int IW = 6,
    parameter int CW = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpts_pkg::t_q_ctrl i_ctrl,
    input  logic [IW-1:0]    i_idx,
    input  tpts_pkg::t_task  i_task,
    output logic             o_ready,
    output logic [IW-1:0]    o_head_idx,
    output tpts_pkg::t_task  o_head_task
);
    import tpts_pkg::*;

    localparam int DEPTH = 2 ** IW;
    localparam int ENT_W = IW + TASK_W;

    logic [ENT_W-1:0] r_mem [DEPTH];
    logic [ENT_W-1:0] r_rd;
    logic [CW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_tail, n_tail;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_ctrl.clear) begin
            n_head = '0;
            n_tail = '0;
        end else begin
            if (i_ctrl.pop) begin
                n_head = r_head + CW'(1);
            end
            if (i_ctrl.push) begin
                n_tail = r_tail + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_tail[IW-1:0]] <= {i_idx, i_task};
        end
        r_rd <= r_mem[n_head[IW-1:0]];
    end

    assign o_ready     = (r_head != r_tail);
    assign o_head_idx  = r_rd[ENT_W-1 -: IW];
    assign o_head_task = t_task'(r_rd[TASK_W-1:0]);

endmodule

[hw/rtl/tpts_result_buf.sv]
// Finish-time store indexed by task, and the output register that replays it in input order.
// Read address holds while stalled so the shown transaction stays put. Depends on tpts_pkg.
`timescale 1ns / 1ps

module tpts_result_buf #(
    parameter int IW = 6,
    parameter int CW = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [IW-1:0]               i_wr_idx,
    input  logic [tpts_pkg::TIME_W-1:0] i_wr_time,
    input  logic                        i_start,
    input  logic [CW-1:0]               i_count,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [tpts_pkg::TIME_W-1:0] o_finish_time,
    output logic                        o_last_result,
    output logic                        o_done
);
    import tpts_pkg::*;

    localparam int DEPTH = 2 ** IW;

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rd;
    logic              r_ov;
    logic [IW-1:0]     r_ok;
    logic [IW-1:0]     rd_addr;
    logic              adv;
    logic              is_last;

    assign adv     = r_ov && !i_stall;
    assign is_last = ((CW'(r_ok) + CW'(1)) == i_count);

    always_comb begin
        if (i_start) begin
            rd_addr = '0;
        end else if (adv) begin
            rd_addr = r_ok + IW'(1);
        end else begin
            rd_addr = r_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_ok <= '0;
        end else if (i_start) begin
            r_ov <= 1'b1;
            r_ok <= '0;
        end else if (adv) begin
            r_ov <= !is_last;
            r_ok <= r_ok + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_time;
        end
        r_rd <= r_mem[rd_addr];
    end

    assign o_valid       = r_ov;
    assign o_finish_time = r_rd;
    assign o_last_result = r_ov && is_last;
    assign o_done        = adv && is_last;

endmodule

[hw/rtl/two_level_priority_task_scheduler_core.sv]
// Top level of the two-level non-preemptive priority task scheduler.
// Instantiates tpts_queue (high and low) and tpts_result_buf; depends on tpts_pkg.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------------
//  task    | in        | i_valid / o_stall | i_arrival_time, i_work_time,
//          |           |                   | i_is_low_priority, i_last_task
//  finish  | out       | o_valid / i_stall | o_finish_time, o_last_result
//
// A batch of n tasks loads at one transaction per cycle, then S_PRIME primes the queue heads,
// S_SCHED schedules one pick per cycle from the prefetched heads, S_FLUSH primes the finish
// store and S_OUT replays the results, one per cycle while i_stall is low.
// o_stall is high from the last task of a batch until its last result is taken.
// Synchronous active-low reset empties both queues; memories are not cleared.
`timescale 1ns / 1ps

module two_level_priority_task_scheduler_core #(
    parameter int MAX_TASKS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [tpts_pkg::ARR_W-1:0]  i_arrival_time,
    input  logic [tpts_pkg::WORK_W-1:0] i_work_time,
    input  logic                        i_is_low_priority,
    input  logic                        i_last_task,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tpts_pkg::TIME_W-1:0] o_finish_time,
    output logic                        o_last_result
);
    import tpts_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PRIME,
        S_SCHED,
        S_FLUSH,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_done;
    logic [ARR_W-1:0]  r_first;
    logic [TIME_W-1:0] r_cur;

    logic              in_acc;
    logic              batch_end;
    t_task             in_task;
    t_q_ctrl           hq_ctrl, lq_ctrl;
    logic              h_rdy, l_rdy;
    logic [IW-1:0]     h_idx, l_idx, sel_idx;
    t_task             h_task, l_task, sel_task;
    logic [TIME_W-1:0] ha, la, sel_arr, start_t, cur_n;
    logic              pick_high;
    logic              sched;
    logic              out_done;

    assign o_stall   = (r_state != S_LOAD);
    assign in_acc    = i_valid && (r_state == S_LOAD);
    assign batch_end = i_last_task || ((r_count + CW'(1)) == CW'(MAX_TASKS));
    assign in_task   = '{arrival: i_arrival_time, work: i_work_time};
    assign sched     = (r_state == S_SCHED);

    assign ha        = TIME_W'(h_task.arrival);
    assign la        = TIME_W'(l_task.arrival);
    assign pick_high = h_rdy && (!l_rdy || (ha <= r_cur) || (ha <= la));
    assign sel_task  = pick_high ? h_task : l_task;
    assign sel_idx   = pick_high ? h_idx : l_idx;
    assign sel_arr   = TIME_W'(sel_task.arrival);
    assign start_t   = (sel_arr > r_cur) ? sel_arr : r_cur;
    assign cur_n     = start_t + TIME_W'(sel_task.work);

    assign hq_ctrl = '{push: in_acc && !i_is_low_priority, pop: sched && pick_high,
                       clear: out_done};
    assign lq_ctrl = '{push: in_acc && i_is_low_priority, pop: sched && !pick_high,
                       clear: out_done};

    tpts_queue #(.IW(IW), .CW(CW)) u_high_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (hq_ctrl),
        .i_idx       (r_count[IW-1:0]),
        .i_task      (in_task),
        .o_ready     (h_rdy),
        .o_head_idx  (h_idx),
        .o_head_task (h_task)
    );

    tpts_queue #(.IW(IW), .CW(CW)) u_low_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (lq_ctrl),
        .i_idx       (r_count[IW-1:0]),
        .i_task      (in_task),
        .o_ready     (l_rdy),
        .o_head_idx  (l_idx),
        .o_head_task (l_task)
    );

    tpts_result_buf #(.IW(IW), .CW(CW)) u_result (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (sched),
        .i_wr_idx      (sel_idx),
        .i_wr_time     (cur_n),
        .i_start       (r_state == S_FLUSH),
        .i_count       (r_count),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_finish_time (o_finish_time),
        .o_last_result (o_last_result),
        .o_done        (out_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_done  <= '0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_count == '0) begin
                            r_first <= i_arrival_time;
                        end
                        r_count <= r_count + CW'(1);
                        if (batch_end) begin
                            r_state <= S_PRIME;
                        end
                    end
                end
                S_PRIME: begin
                    r_cur   <= TIME_W'(r_first);
                    r_done  <= '0;
                    r_state <= S_SCHED;
                end
                S_SCHED: begin
                    r_cur  <= cur_n;
                    r_done <= r_done + CW'(1);
                    if ((r_done + CW'(1)) == r_count) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_done) begin
                        r_count <= '0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule
